>>> src/tcp_pkg.sv
// tilt controller package: payload structs, fixed-point constants, register indexes
// and the cordic arctangent table; no dependencies
`default_nettype none

package tcp_pkg;

    typedef struct packed {
        logic signed [31:0] accel_y;
        logic signed [31:0] accel_z;
        logic signed [31:0] gyro_x;
    } t_in_item;

    typedef struct packed {
        logic        [11:0] motor_level;
        logic        [11:0] smoothed_level;
        logic signed [31:0] angle_estimate;
        logic               integral_saturated;
    } t_out_item;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KP     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KD     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KI     = 2'd3;

    localparam logic signed [23:0] TARGET_RST = -24'sd6029312;
    localparam logic signed [31:0] KP_RST     = 32'sd16384000;
    localparam logic signed [31:0] KD_RST     = 32'sd6553600;
    localparam logic signed [31:0] KI_RST     = 32'sd1311;

    localparam logic signed [32:0] W_SMALL = 33'sd66;
    localparam logic signed [32:0] W_LARGE = 33'sd65470;
    localparam logic signed [35:0] INTEG_LIMIT = 36'sd10485760000;

    localparam int ANG_W = 26;
    localparam int CX_W  = 35;

    localparam logic signed [ANG_W-1:0] ANG_90 = 26'sd5898240;

    function automatic logic [22:0] atan_deg(input logic [4:0] idx);
        logic [22:0] v;
        case (idx)
            5'd0:  v = 23'd2949120;
            5'd1:  v = 23'd1740967;
            5'd2:  v = 23'd919879;
            5'd3:  v = 23'd466945;
            5'd4:  v = 23'd234379;
            5'd5:  v = 23'd117304;
            5'd6:  v = 23'd58666;
            5'd7:  v = 23'd29335;
            5'd8:  v = 23'd14668;
            5'd9:  v = 23'd7334;
            5'd10: v = 23'd3667;
            5'd11: v = 23'd1833;
            5'd12: v = 23'd917;
            5'd13: v = 23'd458;
            5'd14: v = 23'd229;
            5'd15: v = 23'd115;
            5'd16: v = 23'd57;
            5'd17: v = 23'd29;
            5'd18: v = 23'd14;
            5'd19: v = 23'd7;
            5'd20: v = 23'd4;
            5'd21: v = 23'd2;
            5'd22: v = 23'd1;
            default: v = 23'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> src/tcp_cordic.sv
// vectoring cordic giving -atan2(y, z) in 16.16 degrees, one iteration per cycle
// depends on tcp_pkg
`default_nettype none

module tcp_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [31:0] i_y,
    input  wire logic signed [31:0] i_z,
    output logic                    o_done,
    output logic signed [31:0]      o_angle
);
    import tcp_pkg::*;

    localparam int CW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic [CW-1:0] LAST = CW'(CORDIC_STEPS - 1);

    logic                    r_busy, n_busy;
    logic                    r_done, n_done;
    logic signed [CX_W-1:0]  r_x, n_x, r_y, n_y;
    logic signed [ANG_W-1:0] r_ang, n_ang;
    logic [CW-1:0]           r_i, n_i;

    logic signed [CX_W-1:0]  ys, zs, dx, dy;
    logic signed [ANG_W-1:0] step;

    always_comb begin
        ys     = CX_W'(i_y);
        zs     = CX_W'(i_z);
        dx     = r_y >>> r_i;
        dy     = r_x >>> r_i;
        step   = ANG_W'(atan_deg(5'(r_i)));
        n_busy = r_busy;
        n_done = 1'b0;
        n_x    = r_x;
        n_y    = r_y;
        n_ang  = r_ang;
        n_i    = r_i;
        if (i_start) begin
            n_i = '0;
            if (i_y == 32'sd0 && i_z == 32'sd0) begin
                n_ang  = '0;
                n_done = 1'b1;
                n_busy = 1'b0;
            end else begin
                n_busy = 1'b1;
                if (i_z < 0) begin
                    if (i_y >= 0) begin
                        n_x   = ys;
                        n_y   = -zs;
                        n_ang = ANG_90;
                    end else begin
                        n_x   = -ys;
                        n_y   = zs;
                        n_ang = -ANG_90;
                    end
                end else begin
                    n_x   = zs;
                    n_y   = ys;
                    n_ang = '0;
                end
            end
        end else if (r_busy) begin
            if (r_y >= 0) begin
                n_x   = r_x + dx;
                n_y   = r_y - dy;
                n_ang = r_ang + step;
            end else begin
                n_x   = r_x - dx;
                n_y   = r_y + dy;
                n_ang = r_ang - step;
            end
            n_i = r_i + 1'b1;
            if (r_i == LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_x   <= n_x;
        r_y   <= n_y;
        r_ang <= n_ang;
        r_i   <= n_i;
    end

    assign o_done  = r_done;
    assign o_angle = -32'(r_ang);

endmodule

`default_nettype wire

>>> src/tilt_complementary_pid.sv
// tilt controller top level: low-pass accels, complementary angle, pid drive level
// depends on tcp_pkg and tcp_cordic
//
// channel   direction  handshake           payload
// input     in         i_valid / o_ready   i_data  (t_in_item)
// result    out        o_valid / i_ready   o_data  (t_out_item)
// config    in         i_cfg_we            i_cfg_idx, i_cfg_data
//
// the result and o_ready return together after a transfer, so the block takes no new sample
// until it is through with the last one; each sample needs one cordic pass, and
// the first sample after reset adds a seeding cordic pass
// time is set by the cordic iterations and eight passes through the shared multiplier
// o_ready is high only while idle; a result waiting in o_data does not block a new
// transfer, but the next result waits until that one is taken
`default_nettype none

module tilt_complementary_pid #(
    parameter int MAX_LEVEL    = 4000,
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire tcp_pkg::t_in_item             i_data,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output tcp_pkg::t_out_item                 o_data,
    input  wire logic                          i_cfg_we,
    input  wire logic [tcp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [31:0]                   i_cfg_data
);
    import tcp_pkg::*;

    localparam int LW = $clog2(MAX_LEVEL + 1);
    localparam logic [36:0] MAX_T = 37'(MAX_LEVEL);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SEED  = 7'b0000010,
        S_LP    = 7'b0000100,
        S_CORD  = 7'b0001000,
        S_MUL   = 7'b0010000,
        S_ACC   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic signed [23:0] r_tgt;
    logic signed [31:0] r_kp, r_kd, r_ki;

    t_in_item           r_in, n_in;
    logic               r_seeded, n_seeded;
    logic signed [31:0] r_ly, n_ly, r_lz, n_lz;
    logic signed [31:0] r_tilt, n_tilt;
    logic signed [35:0] r_sum, n_sum;
    logic [LW-1:0]      r_smooth, n_smooth;
    logic signed [31:0] r_acc, n_acc;
    logic signed [33:0] r_t, n_t;
    logic signed [32:0] r_err, n_err;
    logic signed [52:0] r_total, n_total;
    logic               r_sat, n_sat;
    logic [2:0]         r_k, n_k;
    logic signed [65:0] r_prod, n_prod;
    logic               r_ovalid, n_ovalid;
    t_out_item          r_out, n_out;

    logic               cord_start, cord_done;
    logic signed [31:0] cord_y, cord_z, cord_angle;

    logic signed [32:0] mul_a, mul_b, dy, dz;
    logic signed [49:0] prod_sh;
    logic signed [34:0] t_full;
    logic signed [36:0] sum_full;
    logic [36:0]        t16;
    logic [LW-1:0]      level;
    logic signed [LW:0] sdiff;
    logic [31:0]        lvl32, sm32;

    tcp_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cord_start),
        .i_y     (cord_y),
        .i_z     (cord_z),
        .o_done  (cord_done),
        .o_angle (cord_angle)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tgt <= TARGET_RST;
            r_kp  <= KP_RST;
            r_kd  <= KD_RST;
            r_ki  <= KI_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TARGET: r_tgt <= i_cfg_data[23:0];
                REG_KP:     r_kp  <= i_cfg_data;
                REG_KD:     r_kd  <= i_cfg_data;
                REG_KI:     r_ki  <= i_cfg_data;
                default:    r_tgt <= r_tgt;
            endcase
        end
    end

    always_comb begin
        case (r_k)
            3'd0: begin
                mul_a = -33'(r_in.gyro_x);
                mul_b = W_SMALL;
            end
            3'd1: begin
                mul_a = r_t[32:0];
                mul_b = W_LARGE;
            end
            3'd2: begin
                mul_a = 33'(r_acc);
                mul_b = W_SMALL;
            end
            3'd3: begin
                mul_a = r_err;
                mul_b = W_SMALL;
            end
            3'd4: begin
                mul_a = 33'(r_kp);
                mul_b = r_err;
            end
            3'd5: begin
                mul_a = 33'(r_in.gyro_x);
                mul_b = 33'(r_kd);
            end
            3'd6: begin
                mul_a = 33'(r_ki);
                mul_b = 33'($signed(r_sum[35:16]));
            end
            default: begin
                mul_a = 33'(r_ki);
                mul_b = {17'b0, r_sum[15:0]};
            end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_in     = r_in;
        n_seeded = r_seeded;
        n_ly     = r_ly;
        n_lz     = r_lz;
        n_tilt   = r_tilt;
        n_sum    = r_sum;
        n_smooth = r_smooth;
        n_acc    = r_acc;
        n_t      = r_t;
        n_err    = r_err;
        n_total  = r_total;
        n_sat    = r_sat;
        n_k      = r_k;
        n_prod   = r_prod;
        n_ovalid = r_ovalid;
        n_out    = r_out;

        cord_start = 1'b0;
        cord_y     = i_data.accel_y;
        cord_z     = i_data.accel_z;

        dy       = 33'(r_in.accel_y) - 33'(r_ly);
        dz       = 33'(r_in.accel_z) - 33'(r_lz);
        prod_sh  = r_prod[65:16];
        t_full   = 35'(r_t) + 35'(prod_sh);
        sum_full = 37'(r_sum) + 37'(prod_sh);
        t16      = r_total[52:16];
        if (r_total[52]) begin
            level = '0;
        end else if (t16 > MAX_T) begin
            level = LW'(MAX_LEVEL);
        end else begin
            level = t16[LW-1:0];
        end
        sdiff = $signed({1'b0, level}) - $signed({1'b0, r_smooth});
        lvl32 = 32'(level);
        sm32  = 32'(LW'(r_smooth + LW'(sdiff >>> 5)));

        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_in = i_data;
                    if (!r_seeded) begin
                        n_ly       = i_data.accel_y;
                        n_lz       = i_data.accel_z;
                        cord_start = 1'b1;
                        n_state    = S_SEED;
                    end else begin
                        n_state = S_LP;
                    end
                end
            end
            S_SEED: begin
                if (cord_done) begin
                    n_tilt   = cord_angle;
                    n_seeded = 1'b1;
                    n_state  = S_LP;
                end
            end
            S_LP: begin
                n_ly       = r_ly + 32'(dy >>> 4);
                n_lz       = r_lz + 32'(dz >>> 4);
                cord_y     = n_ly;
                cord_z     = n_lz;
                cord_start = 1'b1;
                n_state    = S_CORD;
            end
            S_CORD: begin
                if (cord_done) begin
                    n_acc   = cord_angle;
                    n_k     = '0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = mul_a * mul_b;
                n_state = S_ACC;
            end
            S_ACC: begin
                case (r_k)
                    3'd0: n_t = 34'(r_tilt) + 34'(prod_sh);
                    3'd1: n_t = 34'(prod_sh);
                    3'd2: begin
                        if (t_full > 35'sd2147483647) begin
                            n_tilt = 32'sh7fffffff;
                        end else if (t_full < -35'sd2147483648) begin
                            n_tilt = 32'sh80000000;
                        end else begin
                            n_tilt = t_full[31:0];
                        end
                        n_err = 33'(r_tgt) - 33'(n_tilt);
                    end
                    3'd3: begin
                        if (sum_full > 37'(INTEG_LIMIT)) begin
                            n_sum = INTEG_LIMIT;
                        end else if (sum_full < -37'(INTEG_LIMIT)) begin
                            n_sum = -INTEG_LIMIT;
                        end else begin
                            n_sum = sum_full[35:0];
                        end
                        n_sat = (n_sum == INTEG_LIMIT) || (n_sum == -INTEG_LIMIT);
                    end
                    3'd4: n_total = 53'(prod_sh);
                    3'd6: n_total = r_total + 53'(r_prod);
                    default: n_total = r_total + 53'(prod_sh);
                endcase
                n_k = r_k + 1'b1;
                n_state = (r_k == 3'd7) ? S_OUT : S_MUL;
            end
            S_OUT: begin
                if (!r_ovalid || i_ready) begin
                    n_smooth                 = sm32[LW-1:0];
                    n_out.motor_level        = lvl32[11:0];
                    n_out.smoothed_level     = sm32[11:0];
                    n_out.angle_estimate     = r_tilt;
                    n_out.integral_saturated = r_sat;
                    n_ovalid                 = 1'b1;
                    n_state                  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_seeded <= 1'b0;
            r_ly     <= '0;
            r_lz     <= '0;
            r_tilt   <= '0;
            r_sum    <= '0;
            r_smooth <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_seeded <= n_seeded;
            r_ly     <= n_ly;
            r_lz     <= n_lz;
            r_tilt   <= n_tilt;
            r_sum    <= n_sum;
            r_smooth <= n_smooth;
            r_ovalid <= n_ovalid;
        end
        r_in    <= n_in;
        r_acc   <= n_acc;
        r_t     <= n_t;
        r_err   <= n_err;
        r_total <= n_total;
        r_sat   <= n_sat;
        r_k     <= n_k;
        r_prod  <= n_prod;
        r_out   <= n_out;
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

endmodule

`default_nettype wire

>>> tb/tilt_complementary_pid_tb.sv
// testbench for tilt_complementary_pid: random and directed imu samples, register
// settings and handshake stalls, each result checked against an own fixed-point predictor
// depends on tcp_pkg and the tilt_complementary_pid rtl
`default_nettype none

class tilt_scoreboard;

    localparam longint W_SMALL = 66;
    localparam longint W_LARGE = 65470;
    localparam longint INTEG_LIMIT = 64'sd160000 * 64'sd65536;
    localparam longint MAX_LEVEL = 4000;
    localparam int STEPS = 16;

    longint atan_tab[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                             58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

    longint setpoint, kp, kd, ki;
    longint lp_y, lp_z, angle, err_sum, level_avg;
    bit seeded;
    tcp_pkg::t_out_item levels_due[$];
    int errors;

    function new();
        setpoint = longint'(tcp_pkg::TARGET_RST);
        kp = 16384000;
        kd = 6553600;
        ki = 1311;
        lp_y = 0;
        lp_z = 0;
        angle = 0;
        err_sum = 0;
        level_avg = 0;
        seeded = 0;
        errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
        case (idx)
            tcp_pkg::REG_TARGET: setpoint = longint'($signed(val[23:0]));
            tcp_pkg::REG_KP:     kp = longint'($signed(val));
            tcp_pkg::REG_KD:     kd = longint'($signed(val));
            tcp_pkg::REG_KI:     ki = longint'($signed(val));
            default: ;
        endcase
    endfunction

    // vectoring cordic, returns minus atan2(y, z) in 16.16 degrees
    function longint accel_tilt(longint y, longint z);
        longint x, yy, ang, t, dx, dy;
        x = z;
        yy = y;
        ang = 0;
        if (x == 0 && yy == 0)
            return 0;
        if (x < 0) begin
            if (yy >= 0) begin
                t = x; x = yy; yy = -t; ang = 90 * 65536;
            end else begin
                t = x; x = -yy; yy = t; ang = -90 * 65536;
            end
        end
        for (int i = 0; i < STEPS; i++) begin
            dx = yy >>> i;
            dy = x >>> i;
            if (yy >= 0) begin
                x += dx; yy -= dy; ang += atan_tab[i];
            end else begin
                x -= dx; yy += dy; ang -= atan_tab[i];
            end
        end
        return -ang;
    endfunction

    function void note_sample(tcp_pkg::t_in_item s);
        longint ay, az, gx, acc, delta, t, err, hi, lo, total, level;
        tcp_pkg::t_out_item r;
        ay = longint'(s.accel_y);
        az = longint'(s.accel_z);
        gx = longint'(s.gyro_x);
        if (!seeded) begin
            lp_y = ay;
            lp_z = az;
            angle = accel_tilt(ay, az);
            seeded = 1;
        end
        lp_z += (az - lp_z) >>> 4;
        lp_y += (ay - lp_y) >>> 4;
        acc = accel_tilt(lp_y, lp_z);
        delta = (-gx * W_SMALL) >>> 16;
        t = (((angle + delta) * W_LARGE) >>> 16) + ((acc * W_SMALL) >>> 16);
        if (t > 64'sd2147483647) t = 64'sd2147483647;
        if (t < -64'sd2147483648) t = -64'sd2147483648;
        angle = t;
        err = setpoint - angle;
        err_sum += (err * W_SMALL) >>> 16;
        if (err_sum > INTEG_LIMIT) err_sum = INTEG_LIMIT;
        if (err_sum < -INTEG_LIMIT) err_sum = -INTEG_LIMIT;
        hi = err_sum >>> 16;
        lo = err_sum - hi * 65536;
        total = ((kp * err) >>> 16) + ((gx * kd) >>> 16) + ki * hi + ((ki * lo) >>> 16);
        if (total < 0)
            level = 0;
        else begin
            level = total >>> 16;
            if (level > MAX_LEVEL) level = MAX_LEVEL;
        end
        level_avg += (level - level_avg) >>> 5;
        r.motor_level = level[11:0];
        r.smoothed_level = level_avg[11:0];
        r.angle_estimate = angle[31:0];
        r.integral_saturated = (err_sum == INTEG_LIMIT || err_sum == -INTEG_LIMIT);
        levels_due.push_back(r);
    endfunction

    task report(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    task check_result(tcp_pkg::t_out_item got);
        tcp_pkg::t_out_item want;
        if (levels_due.size() == 0) begin
            report($sformatf("unexpected result %h", got));
            return;
        end
        want = levels_due.pop_front();
        if (got.motor_level !== want.motor_level)
            report($sformatf("motor_level %0d, want %0d", got.motor_level, want.motor_level));
        if (got.smoothed_level !== want.smoothed_level)
            report($sformatf("smoothed_level %0d, want %0d",
                             got.smoothed_level, want.smoothed_level));
        if (got.angle_estimate !== want.angle_estimate)
            report($sformatf("angle_estimate %0d, want %0d",
                             got.angle_estimate, want.angle_estimate));
        if (got.integral_saturated !== want.integral_saturated)
            report($sformatf("integral_saturated %b, want %b",
                             got.integral_saturated, want.integral_saturated));
    endtask

endclass

module tilt_complementary_pid_tb;

    import tcp_pkg::*;

    localparam int SETTLE = 80;
    localparam longint CYCLE_LIMIT = 3000000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic o_ready;
    t_in_item i_data = '0;
    logic o_valid;
    logic i_ready = 0;
    t_out_item o_data;
    logic i_cfg_we = 0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = REG_TARGET;
    logic [31:0] i_cfg_data = '0;

    int idle_in = 0;
    int idle_out = 0;
    longint cycles = 0;
    tilt_scoreboard sb = new();

    tilt_complementary_pid dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= idle_out);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result(o_data);
    end

    task send_sample(t_in_item s);
        @(negedge i_clk);
        if ($urandom_range(0, 99) < idle_in) begin
            i_valid = 0;
            do @(negedge i_clk); while ($urandom_range(0, 99) < idle_in);
        end
        i_valid = 1;
        i_data = s;
        forever begin
            @(posedge i_clk);
            if (o_ready) begin
                sb.note_sample(s);
                break;
            end
        end
    endtask

    task drain();
        @(negedge i_clk);
        i_valid = 0;
        while (sb.levels_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task write_regs(logic [31:0] tgt, logic [31:0] p, logic [31:0] d, logic [31:0] k);
        logic [31:0] vals[4];
        vals = '{tgt, p, d, k};
        for (int i = 0; i < 4; i++) begin
            @(negedge i_clk);
            i_cfg_we = 1;
            i_cfg_idx = CFG_IDX_W'(i);
            i_cfg_data = vals[i];
            sb.set_reg(CFG_IDX_W'(i), vals[i]);
        end
        @(negedge i_clk);
        i_cfg_we = 0;
    endtask

    function automatic t_in_item make_sample(int mode);
        t_in_item s;
        case (mode)
            0, 1, 2, 3, 4, 5: begin
                s.accel_y = $signed($urandom_range(0, 262144)) - 131072;
                s.accel_z = $signed($urandom_range(0, 262144)) - 131072;
                s.gyro_x  = $signed($urandom_range(0, 32768000)) - 16384000;
            end
            6, 7: begin
                s.accel_y = $urandom;
                s.accel_z = $urandom;
                s.gyro_x  = $urandom;
            end
            8: begin
                s.accel_y = ($urandom_range(0, 2) == 0) ? 32'h0 : $urandom;
                s.accel_z = ($urandom_range(0, 2) == 0) ? 32'h0 : $urandom;
                s.gyro_x  = ($urandom_range(0, 1) == 0) ? 32'h8000_0000 : 32'h7fff_ffff;
            end
            default: begin
                s.accel_y = 0;
                s.accel_z = 0;
                s.gyro_x  = 32'h8000_0000;
            end
        endcase
        return s;
    endfunction

    task random_settings();
        logic [31:0] tgt, p, d, k;
        tgt = 32'($signed($urandom_range(0, 11927552)) - 6029312);
        p = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 33554432);
        d = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 13107200);
        k = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 65536);
        write_regs(tgt, p, d, k);
    endtask

    task random_run(int count);
        int run_left;
        t_in_item s;
        run_left = 0;
        for (int n = 0; n < count; n++) begin
            if (run_left > 0) begin
                run_left--;
                s = make_sample(9);
            end else begin
                s = make_sample($urandom_range(0, 8));
                if ($urandom_range(0, 99) == 0)
                    run_left = $urandom_range(20, 200);
            end
            send_sample(s);
            if (n == count / 2 && $urandom_range(0, 1) == 0)
                drain();
        end
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n = 1;

        // first sample seeds the filters at reset settings
        idle_in = 7;
        idle_out = 73;
        send_sample('{accel_y: 32'sd0, accel_z: 32'sd65536, gyro_x: 32'sd0});
        send_sample('{accel_y: 32'sd0, accel_z: 32'sd0, gyro_x: 32'sd0});
        send_sample('{accel_y: 32'sh7fff_ffff, accel_z: 32'sh7fff_ffff,
                      gyro_x: 32'sh7fff_ffff});
        send_sample('{accel_y: 32'sh8000_0000, accel_z: 32'sh8000_0000,
                      gyro_x: 32'sh8000_0000});
        send_sample('{accel_y: 32'sh7fff_ffff, accel_z: 32'sh8000_0000, gyro_x: 32'sd0});
        send_sample('{accel_y: 32'sh8000_0000, accel_z: 32'sh7fff_ffff, gyro_x: -32'sd1});
        send_sample('{accel_y: 32'sd65536, accel_z: -32'sd65536, gyro_x: 32'sd1});
        send_sample('{accel_y: -32'sd65536, accel_z: -32'sd65536, gyro_x: 32'sd16384000});
        send_sample('{accel_y: -32'sd1, accel_z: 32'sd0, gyro_x: -32'sd16384000});
        send_sample('{accel_y: 32'sd0, accel_z: -32'sd1, gyro_x: 32'sd0});
        drain();

        // extreme settings
        write_regs(32'sd5898240, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        for (int n = 0; n < 6; n++)
            send_sample(make_sample(n == 0 ? 8 : 6));
        drain();
        write_regs(-32'sd6029312, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
        for (int n = 0; n < 6; n++)
            send_sample(make_sample(n == 0 ? 8 : 6));
        drain();
        write_regs(32'sd0, 32'sd16384000, 32'sd6553600, 32'sd1311);

        for (int ph = 0; ph < 3; ph++) begin
            idle_in = (ph == 0) ? 7 : (ph == 1) ? 73 : 0;
            idle_out = (ph == 0) ? 73 : (ph == 1) ? 7 : 0;
            for (int seg = 0; seg < 3; seg++) begin
                random_run(196);
                drain();
                random_settings();
            end
        end

        drain();
        if (sb.errors == 0 && sb.levels_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
src/tcp_pkg.sv
src/tcp_cordic.sv
src/tilt_complementary_pid.sv
tb/tilt_complementary_pid_tb.sv
